### hw/rtl/statement_completeness_scanner_macros.svh
// Assertion macros for the checker file of the statement scanner.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef STATEMENT_COMPLETENESS_SCANNER_MACROS_SVH
`define STATEMENT_COMPLETENESS_SCANNER_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define SCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define SCS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/scs_pkg.sv
// Package of the statement completeness scanner: scan mode codes and
// the character codes the scanner reacts to. Depends on nothing.
package scs_pkg;

    // Scan mode, as shown on the result beat.
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_LT      = 3'd3,
        MODE_HEX     = 3'd4,
        MODE_B85     = 3'd5,
        MODE_B85_TIL = 3'd6
    } mode_t;

    // Characters with a meaning to the scanner.
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Layout of the result beat.
    localparam int OUT_W = 16;

endpackage

### hw/rtl/statement_completeness_scanner.sv
// Top level of the statement completeness scanner: mode machine, nesting
// counters and the result register. Depends on scs_pkg.
//
// The scanner takes one byte of statement text per input beat and returns one
// result beat per byte telling whether the text so far is a complete
// statement. A byte is accepted in every cycle in which the result register is
// empty or being drained, so the sustained rate is one byte per clock, and
// each result appears in the cycle after its byte; the single mode and counter
// update per byte is the only work between the state registers and the result
// register. Setting the restart flag on a byte clears all scan state,
// including the sticky overflow flag, before that byte is scanned.
module statement_completeness_scanner #(
    parameter int DEPTH_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] complete, [8:1] brace_level,
                                   // [11:9] scan_mode, [12] overflow, [15:13] zero
);

    localparam int EXT_W = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
    localparam logic signed [DEPTH_BITS-1:0] BRACE_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] BRACE_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [DEPTH_BITS-1:0]        PAREN_MAX = {DEPTH_BITS{1'b1}};

    scs_pkg::mode_t                 mode_reg, mode_next, mode_start;
    logic signed [DEPTH_BITS-1:0]   brace_reg, brace_next, brace_start;
    logic [DEPTH_BITS-1:0]          paren_reg, paren_next, paren_start;
    logic                           ovf_reg, ovf_next, ovf_start;
    logic                           m_tvalid_reg;
    logic [scs_pkg::OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic signed [EXT_W-1:0]        brace_ext;
    logic                           complete;
    logic                           in_fire;

    // A byte is taken whenever the result register is free or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Restart puts the scan back to its reset values before the byte.
    always_comb
    begin
        if (s_tuser)
        begin
            mode_start  = scs_pkg::MODE_NORMAL;
            brace_start = '0;
            paren_start = '0;
            ovf_start   = 1'b0;
        end
        else
        begin
            mode_start  = mode_reg;
            brace_start = brace_reg;
            paren_start = paren_reg;
            ovf_start   = ovf_reg;
        end
    end

    // Mode machine and saturating counters.
    always_comb
    begin
        mode_next  = mode_start;
        brace_next = brace_start;
        paren_next = paren_start;
        ovf_next   = ovf_start;
        unique case (mode_start)
            scs_pkg::MODE_NORMAL:
            begin
                if (s_tdata == scs_pkg::CH_LBRACE)
                begin
                    if (brace_start == BRACE_MAX)
                        ovf_next = 1'b1;
                    else
                        brace_next = brace_start + 1'b1;
                end
                else if (s_tdata == scs_pkg::CH_RBRACE)
                begin
                    if (brace_start == BRACE_MIN)
                        ovf_next = 1'b1;
                    else
                        brace_next = brace_start - 1'b1;
                end
                else if (s_tdata == scs_pkg::CH_LPAREN)
                begin
                    paren_next = DEPTH_BITS'(1);
                    mode_next  = scs_pkg::MODE_STR;
                end
                else if (s_tdata == scs_pkg::CH_LT)
                    mode_next = scs_pkg::MODE_LT;
            end
            scs_pkg::MODE_STR:
            begin
                if (s_tdata == scs_pkg::CH_LPAREN)
                begin
                    if (paren_start == PAREN_MAX)
                        ovf_next = 1'b1;
                    else
                        paren_next = paren_start + 1'b1;
                end
                else if (s_tdata == scs_pkg::CH_RPAREN)
                begin
                    // Count down, and leave the string when the count is zero.
                    if (paren_start > 1)
                        paren_next = paren_start - 1'b1;
                    else
                    begin
                        paren_next = '0;
                        mode_next  = scs_pkg::MODE_NORMAL;
                    end
                end
                else if (s_tdata == scs_pkg::CH_BACKSLASH)
                    mode_next = scs_pkg::MODE_ESC;
            end
            scs_pkg::MODE_ESC:
                mode_next = scs_pkg::MODE_STR;
            scs_pkg::MODE_LT:
            begin
                if (s_tdata == scs_pkg::CH_TILDE)
                    mode_next = scs_pkg::MODE_B85_TIL;
                else if (s_tdata == scs_pkg::CH_GT)
                    mode_next = scs_pkg::MODE_NORMAL;
                else
                    mode_next = scs_pkg::MODE_HEX;
            end
            scs_pkg::MODE_HEX:
            begin
                if (s_tdata == scs_pkg::CH_GT)
                    mode_next = scs_pkg::MODE_NORMAL;
            end
            scs_pkg::MODE_B85:
            begin
                if (s_tdata == scs_pkg::CH_TILDE)
                    mode_next = scs_pkg::MODE_B85_TIL;
            end
            scs_pkg::MODE_B85_TIL:
            begin
                if (s_tdata == scs_pkg::CH_GT)
                    mode_next = scs_pkg::MODE_NORMAL;
                else
                    mode_next = scs_pkg::MODE_B85;
            end
            default:
                mode_next = scs_pkg::MODE_NORMAL;
        endcase
    end

    // Result beat: the low byte of the sign-extended brace count is shown.
    assign brace_ext = EXT_W'(brace_next);
    assign complete  = (mode_next == scs_pkg::MODE_NORMAL)
                    && (brace_next[DEPTH_BITS-1] || (brace_next == '0));
    assign m_tdata_next = {3'b000, ovf_next, mode_next, brace_ext[7:0], complete};

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= scs_pkg::MODE_NORMAL;
            brace_reg <= '0;
            paren_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            brace_reg <= brace_next;
            paren_reg <= paren_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (in_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/scs_checker.sv
// Port-level checker of the statement completeness scanner and its bind.
// Depends on scs_pkg and statement_completeness_scanner_macros.svh.
`include "statement_completeness_scanner_macros.svh"

module scs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result beat holds its value.
    `SCS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // Every accepted byte shows its result in the following cycle.
    `SCS_ASSERT(a_one_cycle, s_tvalid && s_tready |=> m_tvalid, "no result beat after accepted byte")

    // A stalled result blocks the input side.
    `SCS_ASSERT(a_backpressure, m_tvalid && !m_tready |-> !s_tready, "byte accepted while result stalled")

    // A restart with an opening brace gives depth one, normal mode and no overflow.
    `SCS_ASSERT(a_restart_brace, s_tvalid && s_tready && s_tuser && (s_tdata == scs_pkg::CH_LBRACE) |=> (m_tdata[8:1] == 8'd1) && (m_tdata[11:9] == scs_pkg::MODE_NORMAL) && !m_tdata[12] && !m_tdata[0], "restart with brace gave wrong result")

    // No result beat is shown while in reset.
    `SCS_ASSERT_RST(a_reset_empty, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind statement_completeness_scanner scs_checker u_scs_checker (.*);

### sim/statement_completeness_scanner_tb.sv
// Testbench of statement_completeness_scanner: directed, nesting-limit and random statement
// streams with random gaps and stalls, checked beat by beat against a behavioral predictor.
// Depends on scs_pkg and the scanner RTL only.
module statement_completeness_scanner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_BITS   = 8;
    localparam int RANDOM_ITEMS = 570;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic signed [DEPTH_BITS-1:0] BRACE_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] BRACE_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [DEPTH_BITS-1:0]        PAREN_MAX = {DEPTH_BITS{1'b1}};

    // One result beat, split into its fields.
    typedef struct packed {
        logic           complete;
        logic [7:0]     brace_level;
        scs_pkg::mode_t scan_mode;
        logic           overflow;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_byte
    logic        s_tuser;   // [0] restart
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] complete, [8:1] brace_level, [11:9] scan_mode,
                            // [12] overflow, [15:13] zero

    // Predicted scan state.
    scs_pkg::mode_t                scan_mode_q;
    logic signed [DEPTH_BITS-1:0]  brace_q;
    logic [DEPTH_BITS-1:0]         paren_q;
    logic                          overflow_q;

    verdict_t pending_verdicts[$];
    int       mismatch_count;
    int       bytes_sent;
    int       calm_left;
    int       cycle_count;

    statement_completeness_scanner #(
        .DEPTH_BITS(DEPTH_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Advance the predicted scan state by one byte and return the expected verdict.
    function automatic verdict_t scan_byte(logic [7:0] c, logic restart);
        verdict_t v;
        if (restart)
        begin
            scan_mode_q = scs_pkg::MODE_NORMAL;
            brace_q     = '0;
            paren_q     = '0;
            overflow_q  = 1'b0;
        end
        case (scan_mode_q)
            scs_pkg::MODE_NORMAL:
            begin
                if (c == scs_pkg::CH_LBRACE)
                begin
                    if (brace_q == BRACE_MAX)
                        overflow_q = 1'b1;
                    else
                        brace_q = brace_q + 1'b1;
                end
                else if (c == scs_pkg::CH_RBRACE)
                begin
                    if (brace_q == BRACE_MIN)
                        overflow_q = 1'b1;
                    else
                        brace_q = brace_q - 1'b1;
                end
                else if (c == scs_pkg::CH_LPAREN)
                begin
                    paren_q     = DEPTH_BITS'(1);
                    scan_mode_q = scs_pkg::MODE_STR;
                end
                else if (c == scs_pkg::CH_LT)
                    scan_mode_q = scs_pkg::MODE_LT;
            end
            scs_pkg::MODE_STR:
            begin
                if (c == scs_pkg::CH_LPAREN)
                begin
                    if (paren_q == PAREN_MAX)
                        overflow_q = 1'b1;
                    else
                        paren_q = paren_q + 1'b1;
                end
                else if (c == scs_pkg::CH_RPAREN)
                begin
                    if (paren_q != 0)
                        paren_q = paren_q - 1'b1;
                    if (paren_q == 0)
                        scan_mode_q = scs_pkg::MODE_NORMAL;
                end
                else if (c == scs_pkg::CH_BACKSLASH)
                    scan_mode_q = scs_pkg::MODE_ESC;
            end
            scs_pkg::MODE_ESC:
                scan_mode_q = scs_pkg::MODE_STR;
            scs_pkg::MODE_LT:
            begin
                if (c == scs_pkg::CH_TILDE)
                    scan_mode_q = scs_pkg::MODE_B85_TIL;
                else if (c == scs_pkg::CH_GT)
                    scan_mode_q = scs_pkg::MODE_NORMAL;
                else
                    scan_mode_q = scs_pkg::MODE_HEX;
            end
            scs_pkg::MODE_HEX:
                if (c == scs_pkg::CH_GT)
                    scan_mode_q = scs_pkg::MODE_NORMAL;
            scs_pkg::MODE_B85:
                if (c == scs_pkg::CH_TILDE)
                    scan_mode_q = scs_pkg::MODE_B85_TIL;
            scs_pkg::MODE_B85_TIL:
                scan_mode_q = (c == scs_pkg::CH_GT) ? scs_pkg::MODE_NORMAL : scs_pkg::MODE_B85;
            default:
                scan_mode_q = scs_pkg::MODE_NORMAL;
        endcase
        v.complete    = (scan_mode_q == scs_pkg::MODE_NORMAL) && (brace_q <= 0);
        v.brace_level = brace_q[7:0];
        v.scan_mode   = scan_mode_q;
        v.overflow    = overflow_q;
        return v;
    endfunction

    // Random byte that has no meaning to the scanner.
    function automatic logic [7:0] plain_byte();
        logic [7:0] r;
        do
            r = 8'($urandom_range(0, 255));
        while (r == scs_pkg::CH_LBRACE || r == scs_pkg::CH_RBRACE ||
               r == scs_pkg::CH_LPAREN || r == scs_pkg::CH_RPAREN ||
               r == scs_pkg::CH_LT || r == scs_pkg::CH_GT ||
               r == scs_pkg::CH_TILDE || r == scs_pkg::CH_BACKSLASH);
        return r;
    endfunction

    // Sender gap: mostly none or short, a few long, and calm stretches without any.
    function automatic int next_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte and hold it until the scanner takes the beat.
    task automatic send_byte(input logic [7:0] c, input logic restart);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(input string text, input logic restart);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], restart && (i == 0));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Record the verdict of each accepted byte, then match each result beat
    // against the oldest verdict still waiting.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_verdicts.push_back(scan_byte(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: result beat with no byte pending, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("complete", want.complete, m_tdata[0]);
                    check_field("brace_level", $signed(want.brace_level),
                                $signed(m_tdata[8:1]));
                    check_field("scan_mode", want.scan_mode, m_tdata[11:9]);
                    check_field("overflow", want.overflow, m_tdata[12]);
                    check_field("pad bits", 0, m_tdata[15:13]);
                end
            end
        end
    end

    // Result side: open stretches, random stalls and a few long stalls.
    initial
    begin
        int kind;
        int span;
        m_tready <= 1'b0;
        forever
        begin
            kind = $urandom_range(0, 9);
            span = (kind == 9) ? $urandom_range(20, 60) : $urandom_range(1, 40);
            repeat (span)
            begin
                @(posedge clk);
                if (kind < 3)
                    m_tready <= 1'b1;
                else if (kind < 9)
                    m_tready <= ($urandom_range(0, 3) != 0);
                else
                    m_tready <= 1'b0;
            end
        end
    end

    // Run guard.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Brace counting, nested strings with escapes, hex and base85 strings, restart.
    task automatic test_directed();
        send_text("{{}}}", 1'b1);
        send_text("x(\\)(a))", 1'b1);
        send_text("<>", 1'b1);
        send_text("<~>", 1'b1);
        send_text("<~~~>", 1'b1);
        send_text("<", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(">", 1'b0);
        send_byte(scs_pkg::CH_LPAREN, 1'b1);
        send_byte(scs_pkg::CH_BACKSLASH, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(scs_pkg::CH_RPAREN, 1'b0);
    endtask

    // Brace saturation at both ends, paren saturation, and restart clearing overflow.
    task automatic test_nesting_limits();
        send_byte(scs_pkg::CH_LBRACE, 1'b1);
        repeat (129) send_byte(scs_pkg::CH_LBRACE, 1'b0);
        repeat (258) send_byte(scs_pkg::CH_RBRACE, 1'b0);
        send_byte(scs_pkg::CH_LPAREN, 1'b1);
        repeat (256) send_byte(scs_pkg::CH_LPAREN, 1'b0);
        repeat (3) send_byte(scs_pkg::CH_RPAREN, 1'b0);
        send_byte(plain_byte(), 1'b1);
    endtask

    // Mostly well-formed statements with random content, some cut short, plus noise.
    task automatic test_random_statements();
        logic [7:0] text[$];
        int         start_count;
        int         braces_open;
        int         level;
        int         cut;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // Noise: any byte, restart now and then.
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            else
            begin
                text.delete();
                braces_open = 0;
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 6))
                        0, 6:
                            text.push_back(plain_byte());
                        1:
                        begin
                            text.push_back(scs_pkg::CH_LBRACE);
                            braces_open++;
                        end
                        2:
                            if (braces_open > 0)
                            begin
                                text.push_back(scs_pkg::CH_RBRACE);
                                braces_open--;
                            end
                        3:
                        begin
                            // Nested parenthesized string with escapes.
                            text.push_back(scs_pkg::CH_LPAREN);
                            level = 1;
                            repeat ($urandom_range(0, 10))
                            begin
                                case ($urandom_range(0, 5))
                                    0:
                                    begin
                                        text.push_back(scs_pkg::CH_LPAREN);
                                        level++;
                                    end
                                    1:
                                        if (level > 1)
                                        begin
                                            text.push_back(scs_pkg::CH_RPAREN);
                                            level--;
                                        end
                                    2:
                                    begin
                                        text.push_back(scs_pkg::CH_BACKSLASH);
                                        text.push_back(8'($urandom_range(0, 255)));
                                    end
                                    default:
                                        text.push_back(plain_byte());
                                endcase
                            end
                            repeat (level) text.push_back(scs_pkg::CH_RPAREN);
                        end
                        4:
                        begin
                            text.push_back(scs_pkg::CH_LT);
                            repeat ($urandom_range(0, 6)) text.push_back(plain_byte());
                            text.push_back(scs_pkg::CH_GT);
                        end
                        5:
                        begin
                            // Base85 string, with lone tildes inside.
                            text.push_back(scs_pkg::CH_LT);
                            text.push_back(scs_pkg::CH_TILDE);
                            repeat ($urandom_range(0, 8))
                            begin
                                if ($urandom_range(0, 3) == 0)
                                    text.push_back(scs_pkg::CH_TILDE);
                                text.push_back(plain_byte());
                            end
                            text.push_back(scs_pkg::CH_TILDE);
                            text.push_back(scs_pkg::CH_GT);
                        end
                    endcase
                end
                repeat (braces_open) text.push_back(scs_pkg::CH_RBRACE);
                if (text.size() > 1 && $urandom_range(0, 5) == 0)
                begin
                    cut = $urandom_range(0, text.size() - 2);
                    text = text[0:cut];
                end
                foreach (text[i])
                    send_byte(text[i], (i == 0) && ($urandom_range(0, 7) != 0));
            end
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        bytes_sent     = 0;
        calm_left      = 0;
        scan_mode_q    = scs_pkg::MODE_NORMAL;
        brace_q        = '0;
        paren_q        = '0;
        overflow_q     = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_nesting_limits();
        test_random_statements();

        // Let the remaining results drain, then allow for the result register.
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
